// ===== rtl/core/ldq_pkg.sv =====
`default_nettype none
package ldq_pkg;

   localparam int DirW  = 16;
   localparam int QuatW = 16;
   localparam int MW    = 34;   // matrix, trace, radicand and difference terms, q.28
   localparam int RemW  = 62;   // square root radicand rad << 28
   localparam int RootW = 31;   // square root result
   localparam int NumW  = 48;   // divider numerator |d| << 14 + s
   localparam int DivW  = 32;   // divisor 2*s
   localparam int QW    = 18;   // quotient bits kept below the overflow flag
   localparam int DiagW = 17;

   localparam logic signed [MW-1:0] OneQ28   = 34'sd268435456;
   localparam logic [QuatW-1:0]     QuatOne  = 16'h4000;
   localparam logic [QuatW-1:0]     QuatMax  = 16'h7fff;
   localparam logic [QuatW-1:0]     QuatMin  = 16'h8000;

   typedef enum logic [1:0] {
      BR_W,
      BR_X,
      BR_Y,
      BR_Z
   } branch_type;

   // classified request handed from front to back
   typedef struct packed {
      branch_type            branch;
      logic                  degen;
      logic signed [MW-1:0]  rad;
      logic [2:0][MW-1:0]    d;
   } cls_type;

   typedef struct packed {
      logic [QuatW-1:0] quat_w;
      logic [QuatW-1:0] quat_x;
      logic [QuatW-1:0] quat_y;
      logic [QuatW-1:0] quat_z;
   } res_type;

endpackage
`default_nettype wire

// ===== rtl/core/look_direction_to_quaternion_unit.sv =====
`default_nettype none
// channel   ports                          handshake
// request   req_dir_x/y/z                  push, full
// response  rsp_quat_w/x/y/z               empty, pop
//
// one request per cycle sustained while full stays low
// latency is set by the 31-stage square root and the 18-stage dividers in the back pipe
// reset clears the pipe valid bits and both queues
// a full response queue freezes the back pipe; the middle queue then fills and raises full
module look_direction_to_quaternion_unit import ldq_pkg::*; #(
   parameter int MID_DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic signed [DirW-1:0]  req_dir_x,
   input  logic signed [DirW-1:0]  req_dir_y,
   input  logic signed [DirW-1:0]  req_dir_z,
   output logic                    empty,
   input  logic                    pop,
   output logic signed [QuatW-1:0] rsp_quat_w,
   output logic signed [QuatW-1:0] rsp_quat_x,
   output logic signed [QuatW-1:0] rsp_quat_y,
   output logic signed [QuatW-1:0] rsp_quat_z
);

   logic    mq_push, mq_full, mq_pop, mq_empty;
   cls_type mq_wr, mq_rd;
   logic    oq_push, oq_full;
   res_type oq_wr, oq_rd;

   ldq_front u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .dir_x  (req_dir_x),
      .dir_y  (req_dir_y),
      .dir_z  (req_dir_z),
      .full   (full),
      .q_push (mq_push),
      .q_data (mq_wr),
      .q_full (mq_full)
   );

   ldq_fifo #(.WIDTH($bits(cls_type)), .DEPTH(MID_DEPTH)) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (mq_push),
      .wr_data (mq_wr),
      .full    (mq_full),
      .pop     (mq_pop),
      .rd_data (mq_rd),
      .empty   (mq_empty)
   );

   ldq_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (mq_empty),
      .q_data  (mq_rd),
      .q_pop   (mq_pop),
      .o_full  (oq_full),
      .o_push  (oq_push),
      .o_data  (oq_wr)
   );

   ldq_fifo #(.WIDTH($bits(res_type)), .DEPTH(2)) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (oq_push),
      .wr_data (oq_wr),
      .full    (oq_full),
      .pop     (pop),
      .rd_data (oq_rd),
      .empty   (empty)
   );

   assign rsp_quat_w = oq_rd.quat_w;
   assign rsp_quat_x = oq_rd.quat_x;
   assign rsp_quat_y = oq_rd.quat_y;
   assign rsp_quat_z = oq_rd.quat_z;

endmodule
`default_nettype wire

// ===== rtl/core/ldq_fifo.sv =====
`default_nettype none
module ldq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ldq_front.sv =====
`default_nettype none
module ldq_front import ldq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic signed [DirW-1:0] dir_x,
   input  logic signed [DirW-1:0] dir_y,
   input  logic signed [DirW-1:0] dir_z,
   output logic                   full,
   output logic                   q_push,
   output cls_type                q_data,
   input  logic                   q_full
);

   logic                   en;
   logic                   a_vld_ff, b_vld_ff;
   logic signed [DirW-1:0] x_ff, y_ff, z_ff;
   logic signed [31:0]     xy_ff, xx_ff, zz_ff, yz_ff;
   cls_type                b_ff, b_in;

   logic signed [MW-1:0] xs, ys, zs;
   logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [MW-1:0] tr, rad_x, rad_y, rad_z, rad_sel;
   logic                 sel_x, sel_y;

   assign en     = !(b_vld_ff && q_full);
   assign full   = !en;
   assign q_push = b_vld_ff && !q_full;
   assign q_data = b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= push;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= dir_x;
         y_ff  <= dir_y;
         z_ff  <= dir_z;
         xy_ff <= 32'(dir_x) * 32'(dir_y);
         xx_ff <= 32'(dir_x) * 32'(dir_x);
         zz_ff <= 32'(dir_z) * 32'(dir_z);
         yz_ff <= 32'(dir_y) * 32'(dir_z);
         b_ff  <= b_in;
      end
   end

   always_comb begin
      xs  = $signed({{(MW-DirW){x_ff[DirW-1]}}, x_ff}) <<< 14;
      ys  = $signed({{(MW-DirW){y_ff[DirW-1]}}, y_ff}) <<< 14;
      zs  = $signed({{(MW-DirW){z_ff[DirW-1]}}, z_ff}) <<< 14;
      m00 = zs;
      m01 = '0;
      m02 = -xs;
      m10 = -$signed({{(MW-32){xy_ff[31]}}, xy_ff});
      m11 = $signed({{(MW-32){xx_ff[31]}}, xx_ff}) + $signed({{(MW-32){zz_ff[31]}}, zz_ff});
      m12 = -$signed({{(MW-32){yz_ff[31]}}, yz_ff});
      m20 = xs;
      m21 = ys;
      m22 = zs;
      tr  = m00 + m11 + m22;

      sel_x = (m00 >= m11) && (m00 >= m22);
      sel_y = (m11 > m22);
      rad_x = OneQ28 + m00 - m11 - m22;
      rad_y = OneQ28 + m11 - m00 - m22;
      rad_z = OneQ28 + m22 - m00 - m11;

      b_in = '0;
      if (!tr[MW-1] && (tr != '0)) begin
         b_in.branch = BR_W;
         b_in.rad    = tr + OneQ28;
         b_in.d[0]   = m12 - m21;
         b_in.d[1]   = m20 - m02;
         b_in.d[2]   = m01 - m10;
      end else if (sel_x) begin
         b_in.branch = BR_X;
         b_in.rad    = rad_x;
         b_in.d[0]   = m12 - m21;
         b_in.d[1]   = m01 + m10;
         b_in.d[2]   = m02 + m20;
      end else if (sel_y) begin
         b_in.branch = BR_Y;
         b_in.rad    = rad_y;
         b_in.d[0]   = m20 - m02;
         b_in.d[1]   = m10 + m01;
         b_in.d[2]   = m21 + m12;
      end else begin
         b_in.branch = BR_Z;
         b_in.rad    = rad_z;
         b_in.d[0]   = m01 - m10;
         b_in.d[1]   = m20 + m02;
         b_in.d[2]   = m21 + m12;
      end
      rad_sel    = b_in.rad;
      // only the axis branches can see a radicand at or below zero
      b_in.degen = (b_in.branch != BR_W) && (rad_sel[MW-1] || (rad_sel == '0));
   end

endmodule
`default_nettype wire

// ===== rtl/core/ldq_back.sv =====
`default_nettype none
module ldq_back import ldq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cls_type q_data,
   output logic    q_pop,
   input  logic    o_full,
   output logic    o_push,
   output res_type o_data
);

   localparam int NStage = 1 + RootW + 1 + QW;

   typedef struct packed {
      branch_type         branch;
      logic               degen;
      logic [2:0][MW-1:0] d;
      logic [RemW-1:0]    rem;
      logic [RootW-1:0]   root;
   } sq_type;

   typedef struct packed {
      branch_type           branch;
      logic                 degen;
      logic [DiagW-1:0]     diag;
      logic [DivW-1:0]      dv;
      logic [2:0][NumW-1:0] rem;
      logic [2:0][QW-1:0]   q;
      logic [2:0]           ov;
      logic [2:0]           neg;
   } dv_type;

   logic              en;
   logic [NStage-1:0] vld_ff;
   sq_type            sq_ff [0:RootW];
   dv_type            dv_ff [0:QW];
   dv_type            prep_in;
   res_type           res;
   logic [2:0][QuatW-1:0] lane_val;
   logic [QuatW-1:0]  diag_val;

   assign en     = !o_full;
   assign q_pop  = en && !q_empty;
   assign o_push = en && vld_ff[NStage-1];
   assign o_data = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NStage-2:0], q_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0].branch <= q_data.branch;
         sq_ff[0].degen  <= q_data.degen;
         sq_ff[0].d      <= q_data.d;
         sq_ff[0].rem    <= {q_data.rad, 28'b0};
         sq_ff[0].root   <= '0;
      end
   end

   // square root, one result bit per stage
   for (genvar i = 0; i < RootW; i++) begin : g_sq
      localparam int K = RootW - 1 - i;
      logic [RemW:0] trial;
      logic          take;
      sq_type        nxt;
      always_comb begin
         trial = ((RemW+1)'(sq_ff[i].root) << (K + 1)) + ((RemW+1)'(1) << (2 * K));
         take  = ({1'b0, sq_ff[i].rem} >= trial);
         nxt   = sq_ff[i];
         if (take) begin
            nxt.rem  = sq_ff[i].rem - trial[RemW-1:0];
            nxt.root = sq_ff[i].root | (RootW'(1) << K);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i+1] <= nxt;
         end
      end
   end

   always_comb begin
      logic [RootW-1:0] s;
      logic [MW-1:0]    mag;
      logic [NumW-1:0]  num;
      s = sq_ff[RootW].root;
      prep_in        = '0;
      prep_in.branch = sq_ff[RootW].branch;
      prep_in.degen  = sq_ff[RootW].degen;
      prep_in.dv     = {s, 1'b0};
      prep_in.diag   = DiagW'((32'(s) + 32'd16384) >> 15);
      for (int j = 0; j < 3; j++) begin
         prep_in.neg[j] = sq_ff[RootW].d[j][MW-1];
         mag = prep_in.neg[j] ? (MW'(0) - sq_ff[RootW].d[j]) : sq_ff[RootW].d[j];
         num = NumW'({mag, 14'b0}) + NumW'(s);
         prep_in.rem[j] = num;
         // quotient of 2^18 or more goes straight to saturation
         prep_in.ov[j]  = (DivW'(num[NumW-1:QW]) >= prep_in.dv);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= prep_in;
      end
   end

   // restoring division, three lanes sharing the divisor
   for (genvar i = 0; i < QW; i++) begin : g_dv
      localparam int K = QW - 1 - i;
      dv_type nxt;
      always_comb begin
         logic [NumW+1:0] cmp;
         nxt = dv_ff[i];
         cmp = (NumW+2)'(dv_ff[i].dv) << K;
         for (int j = 0; j < 3; j++) begin
            if ((NumW+2)'(dv_ff[i].rem[j]) >= cmp) begin
               nxt.rem[j] = dv_ff[i].rem[j] - cmp[NumW-1:0];
               nxt.q[j]   = dv_ff[i].q[j] | (QW'(1) << K);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[i+1] <= nxt;
         end
      end
   end

   always_comb begin
      logic [QW-1:0] negq;
      for (int j = 0; j < 3; j++) begin
         negq = QW'(0) - dv_ff[QW].q[j];
         if (!dv_ff[QW].neg[j]) begin
            lane_val[j] = (dv_ff[QW].ov[j] || (dv_ff[QW].q[j] > QW'(32767)))
                          ? QuatMax : dv_ff[QW].q[j][QuatW-1:0];
         end else begin
            lane_val[j] = (dv_ff[QW].ov[j] || (dv_ff[QW].q[j] > QW'(32768)))
                          ? QuatMin : negq[QuatW-1:0];
         end
      end
      diag_val = (dv_ff[QW].diag > DiagW'(32767)) ? QuatMax : dv_ff[QW].diag[QuatW-1:0];

      unique case (dv_ff[QW].branch)
         BR_W: res = '{quat_w: diag_val,    quat_x: lane_val[0],
                       quat_y: lane_val[1], quat_z: lane_val[2]};
         BR_X: res = '{quat_w: lane_val[0], quat_x: diag_val,
                       quat_y: lane_val[1], quat_z: lane_val[2]};
         BR_Y: res = '{quat_w: lane_val[0], quat_x: lane_val[1],
                       quat_y: diag_val,    quat_z: lane_val[2]};
         BR_Z: res = '{quat_w: lane_val[0], quat_x: lane_val[1],
                       quat_y: lane_val[2], quat_z: diag_val};
         default: res = '0;
      endcase
      if (dv_ff[QW].degen) begin
         res = '{quat_w: QuatOne, quat_x: '0, quat_y: '0, quat_z: '0};
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/ldq_checker.sv =====
`default_nettype none
module ldq_checker import ldq_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    full,
   input logic                    empty,
   input logic                    pop,
   input logic signed [QuatW-1:0] rsp_quat_w,
   input logic signed [QuatW-1:0] rsp_quat_x,
   input logic signed [QuatW-1:0] rsp_quat_y,
   input logic signed [QuatW-1:0] rsp_quat_z
);

   // no response can be waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("response queue not empty after reset");

   // front must be open right after reset
   a_open_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("request side full after reset");

   // a waiting response that is not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_quat_w) && $stable(rsp_quat_x)
                            && $stable(rsp_quat_y) && $stable(rsp_quat_z)))
      else $error("waiting response changed or vanished");

endmodule

bind look_direction_to_quaternion_unit ldq_checker u_ldq_checker (.*);
`default_nettype wire

// ===== bench/look_direction_to_quaternion_checker.sv =====
`timescale 1ns / 100ps
module look_direction_to_quaternion_checker import ldq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic                    full,
   input  logic signed [DirW-1:0]  req_dir_x,
   input  logic signed [DirW-1:0]  req_dir_y,
   input  logic signed [DirW-1:0]  req_dir_z,
   input  logic                    empty,
   input  logic                    pop,
   input  logic signed [QuatW-1:0] rsp_quat_w,
   input  logic signed [QuatW-1:0] rsp_quat_x,
   input  logic signed [QuatW-1:0] rsp_quat_y,
   input  logic signed [QuatW-1:0] rsp_quat_z,
   output int                      fail_count,
   output int                      pending,
   output int                      quat_count
);

   res_type quat_queue[$];

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [QuatW-1:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[QuatW-1:0];
   endfunction

   // numerator / (2*root), rounded half away from zero
   function automatic logic [QuatW-1:0] cross_term(longint d, logic [63:0] s);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (d < 0) ? -d : d;
      q = ((mag << 14) + s) / (2 * s);
      if (q > 65536) q = 65536;
      return clamp16((d < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic logic [QuatW-1:0] half_root(logic [63:0] s);
      logic [63:0] q;
      q = (s + (64'd1 << 14)) >> 15;
      if (q > 65536) q = 65536;
      return clamp16(longint'(q));
   endfunction

   function automatic res_type look_rotation(longint x, longint y, longint z);
      longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, rad;
      logic [63:0] s;
      res_type r;
      m00 = z * 16384; m01 = 0; m02 = -x * 16384;
      m10 = -x * y; m11 = x * x + z * z; m12 = -y * z;
      m20 = x * 16384; m21 = y * 16384; m22 = z * 16384;
      tr = m00 + m11 + m22;
      if (tr > 0) begin
         s = root_floor(64'(tr + (longint'(1) << 28)) << 28);
         r.quat_w = half_root(s);
         r.quat_x = cross_term(m12 - m21, s);
         r.quat_y = cross_term(m20 - m02, s);
         r.quat_z = cross_term(m01 - m10, s);
         return r;
      end
      if (m00 >= m11 && m00 >= m22) rad = (longint'(1) << 28) + m00 - m11 - m22;
      else if (m11 > m22) rad = (longint'(1) << 28) + m11 - m00 - m22;
      else rad = (longint'(1) << 28) + m22 - m00 - m11;
      if (rad <= 0) begin
         r.quat_w = QuatOne; r.quat_x = 0; r.quat_y = 0; r.quat_z = 0;
         return r;
      end
      s = root_floor(64'(rad) << 28);
      if (m00 >= m11 && m00 >= m22) begin
         r.quat_w = cross_term(m12 - m21, s);
         r.quat_x = half_root(s);
         r.quat_y = cross_term(m01 + m10, s);
         r.quat_z = cross_term(m02 + m20, s);
      end else if (m11 > m22) begin
         r.quat_w = cross_term(m20 - m02, s);
         r.quat_x = cross_term(m10 + m01, s);
         r.quat_y = half_root(s);
         r.quat_z = cross_term(m21 + m12, s);
      end else begin
         r.quat_w = cross_term(m01 - m10, s);
         r.quat_x = cross_term(m20 + m02, s);
         r.quat_y = cross_term(m21 + m12, s);
         r.quat_z = half_root(s);
      end
      return r;
   endfunction

   task automatic compare_field(string name, logic [QuatW-1:0] exp_v, logic [QuatW-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d got %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      quat_count = 0;
   end

   always @(posedge clock) begin
      res_type e;
      if (!reset) begin
         if (push && !full)
            quat_queue.push_back(look_rotation(req_dir_x, req_dir_y, req_dir_z));
         if (pop && !empty) begin
            quat_count++;
            if (quat_queue.size() == 0) begin
               $display("%0t: unexpected response %0d %0d %0d %0d", $time,
                        rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z);
               fail_count++;
            end else begin
               e = quat_queue.pop_front();
               compare_field("quat_w", e.quat_w, rsp_quat_w);
               compare_field("quat_x", e.quat_x, rsp_quat_x);
               compare_field("quat_y", e.quat_y, rsp_quat_y);
               compare_field("quat_z", e.quat_z, rsp_quat_z);
            end
         end
         pending = quat_queue.size();
      end
   end

endmodule

// ===== bench/look_direction_to_quaternion_unit_tb.sv =====
`timescale 1ns / 100ps
module look_direction_to_quaternion_unit_tb;
   import ldq_pkg::*;

   localparam int RandomCount = 1530;

   logic clock;
   logic reset;
   logic push;
   logic pop;
   logic full;
   logic empty;
   logic signed [DirW-1:0]  req_dir_x, req_dir_y, req_dir_z;
   logic signed [QuatW-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int fail_count, pending, quat_count;
   int sent;
   bit stim_done;
   bit hold_off;

   look_direction_to_quaternion_unit i_dut (.*);

   look_direction_to_quaternion_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after the request is taken
   task automatic send_dir(logic [DirW-1:0] x, logic [DirW-1:0] y, logic [DirW-1:0] z);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         push <= 0;
         repeat (gap) @(negedge clock);
      end
      push      <= 1;
      req_dir_x <= x;
      req_dir_y <= y;
      req_dir_z <= z;
      do @(posedge clock); while (full);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [DirW-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 32) - 16) << 10;
         2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // unit-length-ish directions from random angle samples
   task automatic send_unit();
      real th, ph;
      th = ($urandom % 100000) / 100000.0 * 6.2831853;
      ph = ($urandom % 100000) / 100000.0 * 3.1415926 - 1.5707963;
      send_dir(16'($rtoi(16384.0 * $cos(ph) * $sin(th))),
               16'($rtoi(16384.0 * $sin(ph))),
               16'($rtoi(16384.0 * $cos(ph) * $cos(th))));
   endtask

   initial begin
      int n;
      push = 0; req_dir_x = 0; req_dir_y = 0; req_dir_z = 0;
      reset = 1; stim_done = 0; sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      send_dir(0, 0, 0);
      send_dir(0, 0, 16384);
      send_dir(0, 0, -16384);
      send_dir(16384, 0, 0);
      send_dir(-16384, 0, 0);
      send_dir(0, 16384, 0);
      send_dir(0, -16384, 0);
      send_dir(16'h7fff, 16'h7fff, 16'h7fff);
      send_dir(16'h8000, 16'h8000, 16'h8000);
      send_dir(16'h7fff, 16'h8000, 16'h7fff);
      send_dir(16'h8000, 16'h7fff, 16'h8000);
      send_dir(16'hffff, 16'h0001, 16'h8000);
      send_dir(11585, 0, -11585);
      send_dir(-11585, 11585, 0);
      send_dir(0, 16'h8000, 0);
      send_dir(16'h5555, 16'haaaa, 16'h5555);
      send_dir(16'haaaa, 16'h5555, 16'haaaa);
      for (n = 0; n < RandomCount; n++) begin
         if ($urandom_range(0, 2) == 0) send_dir(rand_comp(), rand_comp(), rand_comp());
         else send_unit();
      end
      push <= 0;
      stim_done = 1;
   end

   initial begin
      int wait_cycles;
      pop = 0;
      hold_off = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         // long hold-off to back the pipe up once
         if (sent > 300 && !hold_off) begin
            hold_off = 1;
            pop <= 0;
            repeat (400) @(negedge clock);
         end
         wait_cycles = (sent > 900 && sent < 1100) ? 0 : $urandom_range(0, 15);
         if (wait_cycles != 0) begin
            pop <= 0;
            repeat (wait_cycles - 1) @(negedge clock);
            @(negedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
      end
   end

   initial begin
      wait (stim_done);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d directions, checked %0d quaternions", sent, quat_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
